// ===== sv/srtd_pkg.sv =====
`default_nettype none

package srtd_pkg;

  // Ring size and converter width.
  localparam int CHANNELS    = 32;
  localparam int SAMPLE_BITS = 12;

  // Fixed widths of the beat fields.
  localparam int CMD_W     = 2;
  localparam int CH_W      = 5;
  localparam int MASK_W    = 32;
  localparam int COUNT_W   = 6;
  localparam int CFG_IDX_W = 1;
  localparam int CH_IDX_W  = $clog2(CHANNELS);

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CALIBRATE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_START = 1'd1;

  localparam logic [SAMPLE_BITS-1:0] MIN_START_RESET = SAMPLE_BITS'(1200);

  typedef struct packed {
    logic [CMD_W-1:0]       cmd;
    logic [CH_W-1:0]        channel;
    logic [SAMPLE_BITS-1:0] sample_value;
    logic                   scan_last;
  } item_t;

  typedef struct packed {
    logic               above;
    logic [MASK_W-1:0]  hit_mask;
    logic [COUNT_W-1:0] hit_count;
    logic               on_line;
    logic               scan_done;
  } result_t;

  typedef struct packed {
    logic                   valid;
    logic [CFG_IDX_W-1:0]   index;
    logic [SAMPLE_BITS-1:0] data;
  } cfg_wr_t;

endpackage

`default_nettype wire

// ===== sv/srtd_if.sv =====
`default_nettype none

// Sample and command channel.
interface srtd_in_if import srtd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CMD_W-1:0]       cmd;
  logic [CH_W-1:0]        channel;
  logic [SAMPLE_BITS-1:0] sample_value;
  logic                   scan_last;

  modport source (output valid, cmd, channel, sample_value, scan_last, input ready);
  modport sink   (input valid, cmd, channel, sample_value, scan_last, output ready);
endinterface

// Detection result channel.
interface srtd_out_if import srtd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               above;
  logic [MASK_W-1:0]  hit_mask;
  logic [COUNT_W-1:0] hit_count;
  logic               on_line;
  logic               scan_done;

  modport source (output valid, above, hit_mask, hit_count, on_line, scan_done, input ready);
  modport sink   (input valid, above, hit_mask, hit_count, on_line, scan_done, output ready);
endinterface

// Configuration write channel.
interface srtd_cfg_if import srtd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   index;
  logic [SAMPLE_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/srtd_datapath.sv =====
`default_nettype none

module srtd_datapath import srtd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  input  cfg_wr_t cfg_i,
  output result_t res_o
);

  logic                   calibrate_q;
  logic [SAMPLE_BITS-1:0] min_start_q;

  logic [SAMPLE_BITS-1:0] thr_q [CHANNELS];
  logic [SAMPLE_BITS-1:0] min_q [CHANNELS];
  logic [SAMPLE_BITS-1:0] max_q [CHANNELS];
  logic [MASK_W-1:0]      mask_q, mask_d;
  logic [COUNT_W-1:0]     count_q, count_d;

  logic                   valid_ch;
  logic [CH_IDX_W-1:0]    idx;
  logic                   is_sample;
  logic                   above;
  logic                   new_bit;
  logic [MASK_W-1:0]      mask_upd;
  logic [COUNT_W-1:0]     count_upd;
  logic [SAMPLE_BITS-1:0] max_new, min_new, thr_new;
  logic [SAMPLE_BITS:0]   mid_sum;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calibrate_q <= 1'b0;
      min_start_q <= MIN_START_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_CALIBRATE: calibrate_q <= cfg_i.data[0];
        CFG_MIN_START: min_start_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Compare against the threshold held before any calibration update.
  assign valid_ch  = ({1'b0, item_i.channel} < (CH_W + 1)'(CHANNELS));
  assign idx       = item_i.channel[CH_IDX_W-1:0];
  assign is_sample = (item_i.cmd == CMD_SAMPLE);
  assign above     = is_sample && valid_ch && (item_i.sample_value > thr_q[idx]);
  assign new_bit   = above && !mask_q[item_i.channel];
  assign mask_upd  = mask_q | (MASK_W'(new_bit) << item_i.channel);
  assign count_upd = count_q + COUNT_W'(new_bit);

  // Running extremes and their midpoint.
  assign max_new = (item_i.sample_value > max_q[idx]) ? item_i.sample_value : max_q[idx];
  assign min_new = (item_i.sample_value < min_q[idx]) ? item_i.sample_value : min_q[idx];
  assign mid_sum = {1'b0, max_new} + {1'b0, min_new};
  assign thr_new = mid_sum[SAMPLE_BITS:1];

  // Result of this beat and the scan state that follows it.
  always_comb begin
    res_o   = '0;
    mask_d  = mask_q;
    count_d = count_q;
    if (is_sample) begin
      res_o.above     = above;
      res_o.hit_mask  = mask_upd;
      res_o.hit_count = count_upd;
      res_o.scan_done = item_i.scan_last;
      res_o.on_line   = item_i.scan_last && (count_upd != '0);
      if (item_i.scan_last) begin
        mask_d  = '0;
        count_d = '0;
      end else begin
        mask_d  = mask_upd;
        count_d = count_upd;
      end
    end else begin
      res_o.hit_mask  = mask_q;
      res_o.hit_count = count_q;
    end
  end

  // Scan accumulator.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= '0;
      count_q <= '0;
    end else if (fire_i) begin
      mask_q  <= mask_d;
      count_q <= count_d;
    end
  end

  // Per-channel threshold, minimum and maximum stores.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        thr_q[i] <= '0;
        min_q[i] <= MIN_START_RESET;
        max_q[i] <= '0;
      end
    end else if (fire_i) begin
      case (item_i.cmd)
        CMD_SAMPLE: begin
          if (valid_ch && calibrate_q) begin
            max_q[idx] <= max_new;
            min_q[idx] <= min_new;
            thr_q[idx] <= thr_new;
          end
        end
        CMD_LOAD: begin
          if (valid_ch) begin
            thr_q[idx] <= item_i.sample_value;
          end
        end
        CMD_CLEAR: begin
          for (int i = 0; i < CHANNELS; i++) begin
            min_q[i] <= min_start_q;
            max_q[i] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/sensor_ring_threshold_detect_top.sv =====
// Threshold detector for a ring of light sensor channels, with min/max calibration.
// in_i carries one beat per command: a converter sample for a channel, a direct
// threshold load, or a clear of the calibration extremes. Channels are scanned in
// order and scan_last marks the beat that closes a scan.
// out_o returns exactly one result beat per input beat, in order: the compare
// result, the running hit mask and hit count, and on_line/scan_done on the closing
// sample. cfg_i writes the calibrate mode and the minimum start value; write it
// only while no beat is in flight. cfg_i is always ready.
// An accepted input beat passes through the input register, then the result
// register, to its result beat. One beat is taken every cycle while the
// receiver keeps up; a beat's per-channel compare and min/max/midpoint update
// commit as it leaves the input register, so the next beat sees the updated stores.
// Reset clears thresholds and maxima to zero, minima to 1200, the scan to empty,
// calibrate mode off and the minimum start value to 1200. When the receiver stalls
// the result register holds its beat and the input register takes one more beat,
// after which in_i.ready drops until out_o.ready returns.
`default_nettype none

module sensor_ring_threshold_detect_top import srtd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  srtd_in_if.sink     in_i,
  srtd_out_if.source  out_o,
  srtd_cfg_if.sink    cfg_i
);

  logic    a_valid_q;
  item_t   a_item_q;
  logic    b_valid_q;
  result_t b_res_q;
  result_t res;
  cfg_wr_t cfg_wr;
  logic    b_load;
  logic    a_adv;
  logic    in_fire;

  // Pipeline flow control.
  assign b_load      = !b_valid_q || out_o.ready;
  assign a_adv       = a_valid_q && b_load;
  assign in_i.ready  = !a_valid_q || b_load;
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign cfg_wr.valid = cfg_i.valid;
  assign cfg_wr.index = cfg_i.index;
  assign cfg_wr.data  = cfg_i.data;

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_fire) begin
      a_valid_q <= 1'b1;
    end else if (a_adv) begin
      a_valid_q <= 1'b0;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_item_q.cmd          <= in_i.cmd;
      a_item_q.channel      <= in_i.channel;
      a_item_q.sample_value <= in_i.sample_value;
      a_item_q.scan_last    <= in_i.scan_last;
    end
  end

  srtd_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (a_adv),
    .item_i (a_item_q),
    .cfg_i  (cfg_wr),
    .res_o  (res)
  );

  // Result register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_load) begin
      b_valid_q <= a_valid_q;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      b_res_q <= res;
    end
  end

  assign out_o.valid     = b_valid_q;
  assign out_o.above     = b_res_q.above;
  assign out_o.hit_mask  = b_res_q.hit_mask;
  assign out_o.hit_count = b_res_q.hit_count;
  assign out_o.on_line   = b_res_q.on_line;
  assign out_o.scan_done = b_res_q.scan_done;

`ifndef NO_ASSERTIONS
  // The hit count always matches the number of channels set in the mask.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.hit_count == COUNT_W'($countones(out_o.hit_mask)))
    else $error("hit count does not match hit mask");

  // On-line is only reported on a scan-closing beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.on_line |-> out_o.scan_done)
    else $error("on_line without scan_done");

  // A hit always leaves at least one bit in the mask.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.above |-> out_o.hit_mask != '0)
    else $error("above set with empty hit mask");

  // An accepted beat is held in the input register on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> a_valid_q)
    else $error("accepted beat lost from input register");
`endif

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import srtd_pkg::*;

  // Command code that the block treats as a no-op.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Cycles to let pass after the last result before a register write.
  localparam int SETTLE_CYCLES = 4;
  // Cycles without any accepted beat before the run is declared hung.
  localparam int STALL_LIMIT   = 5000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Signals the testbench drives into the channels.
  item_t                  src_item  = '0;
  logic                   src_valid = 1'b0;
  logic                   snk_ready = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [SAMPLE_BITS-1:0] cfg_data  = '0;

  // Beats waiting to be sent, and detections waiting to come back.
  item_t   sensor_beats[$];
  cfg_wr_t reg_writes[$];
  result_t expected_detections[$];

  // Idle and stall rates in percent, set per phase.
  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;

  // Run bookkeeping.
  int unsigned fail_count   = 0;
  int unsigned beats_queued = 0;
  int unsigned beats_in     = 0;
  int unsigned results_seen = 0;
  int unsigned scans_closed = 0;
  int unsigned scans_online = 0;
  int unsigned scans_full   = 0;
  int unsigned idle_cycles  = 0;

  // Shadow copy of the detector state.
  logic [SAMPLE_BITS-1:0] thresh_m [CHANNELS];
  logic [SAMPLE_BITS-1:0] min_m    [CHANNELS];
  logic [SAMPLE_BITS-1:0] max_m    [CHANNELS];
  logic [MASK_W-1:0]      mask_m;
  logic [COUNT_W-1:0]     count_m;
  logic                   calib_m;
  logic [SAMPLE_BITS-1:0] min_start_m;

  srtd_in_if  in_if  ();
  srtd_out_if out_if ();
  srtd_cfg_if cfg_if ();

  assign in_if.valid        = src_valid;
  assign in_if.cmd          = src_item.cmd;
  assign in_if.channel      = src_item.channel;
  assign in_if.sample_value = src_item.sample_value;
  assign in_if.scan_last    = src_item.scan_last;
  assign out_if.ready       = snk_ready;
  assign cfg_if.valid       = cfg_valid;
  assign cfg_if.index       = cfg_index;
  assign cfg_if.data        = cfg_data;

  sensor_ring_threshold_detect_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  // Return minima to the start value and maxima to zero.
  function automatic void reset_extremes();
    foreach (min_m[i]) begin
      min_m[i] = min_start_m;
      max_m[i] = '0;
    end
  endfunction

  // Compute the detection for one command beat and advance the shadow state.
  function automatic result_t predict_detection(item_t it);
    result_t              r;
    logic [SAMPLE_BITS:0] mid_sum;
    r = '0;
    case (it.cmd)
      CMD_SAMPLE: begin
        // Compare against the threshold held before any calibration update.
        r.above = it.sample_value > thresh_m[it.channel];
        if (r.above && !mask_m[it.channel]) begin
          mask_m[it.channel] = 1'b1;
          count_m = count_m + 1'b1;
        end
        if (calib_m) begin
          if (it.sample_value > max_m[it.channel]) max_m[it.channel] = it.sample_value;
          if (it.sample_value < min_m[it.channel]) min_m[it.channel] = it.sample_value;
          mid_sum = max_m[it.channel] + min_m[it.channel];
          thresh_m[it.channel] = mid_sum[SAMPLE_BITS:1];
        end
        r.hit_mask  = mask_m;
        r.hit_count = count_m;
        // The closing sample reports the scan and then empties it.
        if (it.scan_last) begin
          r.scan_done = 1'b1;
          r.on_line   = (count_m != '0);
          mask_m      = '0;
          count_m     = '0;
        end
      end
      CMD_LOAD: begin
        thresh_m[it.channel] = it.sample_value;
      end
      CMD_CLEAR: begin
        reset_extremes();
      end
      default: begin
      end
    endcase
    if (it.cmd != CMD_SAMPLE) begin
      r.hit_mask  = mask_m;
      r.hit_count = count_m;
    end
    return r;
  endfunction

  // Command beat driver.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      src_valid <= 1'b0;
    end else begin
      if (src_valid && in_if.ready) begin
        expected_detections.push_back(predict_detection(src_item));
        beats_in++;
      end
      if (!src_valid || in_if.ready) begin
        if (sensor_beats.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          src_item  <= sensor_beats.pop_front();
          src_valid <= 1'b1;
        end else begin
          src_valid <= 1'b0;
        end
      end
    end
  end

  // Register write driver; the shadow registers follow each accepted write.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cfg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_if.ready) begin
        if (cfg_index == CFG_CALIBRATE) begin
          calib_m = cfg_data[0];
        end else begin
          min_start_m = cfg_data;
        end
      end
      if (!cfg_valid || cfg_if.ready) begin
        if (reg_writes.size() != 0) begin
          cfg_index <= reg_writes[0].index;
          cfg_data  <= reg_writes[0].data;
          cfg_valid <= 1'b1;
          void'(reg_writes.pop_front());
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [MASK_W-1:0] want_v, logic [MASK_W-1:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      fail_count++;
    end
  endtask

  // Result monitor with random back-pressure.
  always @(posedge clk_i) begin
    result_t want;
    if (!rst_ni) begin
      snk_ready <= 1'b0;
    end else begin
      if (out_if.valid && snk_ready) begin
        results_seen++;
        if (expected_detections.size() == 0) begin
          $error("result beat arrived with no detection expected");
          fail_count++;
        end else begin
          want = expected_detections.pop_front();
          check_field("above", want.above, out_if.above);
          check_field("hit_mask", want.hit_mask, out_if.hit_mask);
          check_field("hit_count", want.hit_count, out_if.hit_count);
          check_field("on_line", want.on_line, out_if.on_line);
          check_field("scan_done", want.scan_done, out_if.scan_done);
          if (want.scan_done) begin
            scans_closed++;
            if (want.on_line) scans_online++;
            if (want.hit_count == CHANNELS) scans_full++;
          end
        end
      end
      snk_ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Watchdog on cycles with no accepted beat on any channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (src_valid && in_if.ready) || (out_if.valid && snk_ready) ||
        (cfg_valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic push_item(logic [CMD_W-1:0] cmd, int ch, int val, bit last);
    item_t it;
    it.cmd          = cmd;
    it.channel      = CH_W'(ch);
    it.sample_value = SAMPLE_BITS'(val);
    it.scan_last    = last;
    sensor_beats.push_back(it);
    beats_queued++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_wr_t w;
    w.valid = 1'b1;
    w.index = idx;
    w.data  = SAMPLE_BITS'(val);
    reg_writes.push_back(w);
    do @(negedge clk_i); while (reg_writes.size() != 0 || cfg_valid);
  endtask

  // Hold off until every queued beat has its detection back, then settle.
  task automatic drain();
    while (sensor_beats.size() != 0 || src_valid || expected_detections.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Converter value: any nonzero value when bright, else extremes, values near mid-scale, or anything.
  function automatic int pick_value(bit bright);
    int unsigned r;
    r = $urandom_range(99);
    if (bright) return $urandom_range(1, 4095);
    if (r < 8) return 0;
    if (r < 16) return 4095;
    if (r < 40) return $urandom_range(1984, 2111);
    return $urandom_range(4095);
  endfunction

  // Random traffic: mostly in-order scans, plus threshold sweeps, repeats and noise.
  task automatic run_phase(int unsigned target);
    int unsigned start_n;
    int unsigned pick;
    int unsigned len;
    bit          bright;
    start_n = beats_queued;
    push_item(CMD_CLEAR, $urandom_range(31), $urandom_range(4095), $urandom_range(1));
    while (beats_queued - start_n < target) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        len    = ($urandom_range(7) == 0) ? $urandom_range(1, CHANNELS - 1) : CHANNELS;
        bright = $urandom_range(1);
        for (int ch = 0; ch < len; ch++) begin
          if ($urandom_range(24) == 0) begin
            push_item($urandom_range(1) ? CMD_LOAD : CMD_CLEAR, $urandom_range(31),
                      pick_value(1'b0), $urandom_range(1));
          end
          push_item(CMD_SAMPLE, ch, pick_value(bright), ch == len - 1);
        end
      end else if (pick < 70) begin
        for (int ch = 0; ch < CHANNELS; ch++)
          push_item(CMD_LOAD, ch, pick_value(1'b0), $urandom_range(1));
      end else if (pick < 82) begin
        len = $urandom_range(1, 40);
        for (int k = 0; k < len; k++)
          push_item(CMD_SAMPLE, $urandom_range(7), pick_value(1'b0), k == len - 1);
      end else begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++)
          push_item(CMD_W'($urandom_range(3)), $urandom_range(31), $urandom_range(4095),
                    $urandom_range(1));
      end
    end
  endtask

  initial begin
    // Shadow state after reset.
    foreach (thresh_m[i]) thresh_m[i] = '0;
    calib_m     = 1'b0;
    min_start_m = MIN_START_RESET;
    reset_extremes();
    mask_m  = '0;
    count_m = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    write_reg(CFG_CALIBRATE, 0);
    write_reg(CFG_MIN_START, MIN_START_RESET);

    // Directed detection checks with reset thresholds.
    push_item(CMD_SAMPLE, 0, 0, 1'b0);
    push_item(CMD_SAMPLE, 1, 1, 1'b0);
    push_item(CMD_SAMPLE, 31, 4095, 1'b0);
    // Same channel twice counts once.
    push_item(CMD_SAMPLE, 1, 4095, 1'b0);
    // A load ignores scan_last.
    push_item(CMD_LOAD, 2, 4095, 1'b1);
    // Equal to the threshold is not a hit.
    push_item(CMD_SAMPLE, 2, 4095, 1'b0);
    push_item(CMD_SAMPLE, 3, 2, 1'b1);
    // Scan closed with no hits.
    push_item(CMD_SAMPLE, 4, 0, 1'b1);
    push_item(CMD_UNUSED, 5, 123, 1'b1);
    push_item(CMD_CLEAR, 31, 4095, 1'b1);
    push_item(CMD_LOAD, 5, 4094, 1'b0);
    push_item(CMD_SAMPLE, 5, 4095, 1'b0);
    push_item(CMD_SAMPLE, 5, 4094, 1'b1);
    drain();

    // Directed calibration checks with the highest minimum start.
    write_reg(CFG_CALIBRATE, 1);
    write_reg(CFG_MIN_START, 4095);
    push_item(CMD_CLEAR, 0, 0, 1'b0);
    push_item(CMD_SAMPLE, 6, 100, 1'b0);
    push_item(CMD_SAMPLE, 6, 100, 1'b0);
    push_item(CMD_SAMPLE, 6, 0, 1'b0);
    push_item(CMD_SAMPLE, 6, 51, 1'b0);
    push_item(CMD_SAMPLE, 7, 4095, 1'b1);
    push_item(CMD_SAMPLE, 7, 4095, 1'b0);
    push_item(CMD_LOAD, 7, 10, 1'b0);
    // Clearing extremes keeps the loaded threshold.
    push_item(CMD_CLEAR, 0, 0, 1'b0);
    push_item(CMD_SAMPLE, 7, 11, 1'b1);
    drain();

    // Detection only, random minimum start, no idling.
    write_reg(CFG_CALIBRATE, 0);
    write_reg(CFG_MIN_START, $urandom_range(4095));
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    run_phase(130);
    drain();

    // Calibration from a zero minimum start, sender idling; pause midway.
    write_reg(CFG_CALIBRATE, 1);
    write_reg(CFG_MIN_START, 0);
    src_idle_pct  = 59;
    snk_stall_pct = 0;
    run_phase(60);
    drain();
    run_phase(60);
    drain();

    // Calibration from the top minimum start, receiver stalling.
    write_reg(CFG_MIN_START, 4095);
    src_idle_pct  = 0;
    snk_stall_pct = 59;
    run_phase(130);
    drain();

    // Detection with random start, both sides idling.
    write_reg(CFG_CALIBRATE, 0);
    write_reg(CFG_MIN_START, $urandom_range(4095));
    src_idle_pct  = 31;
    snk_stall_pct = 31;
    run_phase(130);
    drain();

    // Calibration from the reset start value, no idling.
    write_reg(CFG_CALIBRATE, 1);
    write_reg(CFG_MIN_START, MIN_START_RESET);
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    run_phase(130);
    drain();
    repeat (10) @(negedge clk_i);

    $display("Sent %0d command beats over directed and six random phases, calibrate on and off.",
             beats_in);
    $display("Checked %0d results: %0d scans closed, %0d on line, %0d with every channel hit.",
             results_seen, scans_closed, scans_online, scans_full);
    if (fail_count == 0 && expected_detections.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
